FILE: rtl/srmt_pkg.sv
package srmt_pkg;

  localparam int unsigned IdW         = 16;
  localparam int unsigned OpW         = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountOutW   = 5;
  localparam int unsigned MaxMembersDef = 16;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2,
    OP_NEIGH  = 2'd3
  } srmt_op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } srmt_status_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic           upd;  // apply a shift this cycle
    logic           ins;  // 1: insert (shift right), 0: remove (shift left)
    logic [IdW-1:0] id;   // identifier under test
  } srmt_cmd_t;

endpackage

FILE: rtl/srmt_in_if.sv
interface srmt_in_if import srmt_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] operation;
  logic [IdW-1:0] member_id;

  modport source (output valid, output operation, output member_id, input ready);
  modport sink (input valid, input operation, input member_id, output ready);
endinterface

FILE: rtl/srmt_out_if.sv
interface srmt_out_if import srmt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic                 present;
  logic                 pred_valid;
  logic [IdW-1:0]       predecessor;
  logic                 succ_valid;
  logic [IdW-1:0]       successor;
  logic [CountOutW-1:0] member_count;

  modport source (output valid, output status, output present, output pred_valid,
                  output predecessor, output succ_valid, output successor,
                  output member_count, input ready);
  modport sink (input valid, input status, input present, input pred_valid,
                input predecessor, input succ_valid, input successor,
                input member_count, output ready);
endinterface

FILE: rtl/sorted_ring_member_table_top.sv
// An item is accepted in the idle state; its result is registered in the
// evaluate state that follows, once the output register is free. No item is
// taken in the evaluate state, where all cells of the chain compare and shift
// at once. The next item is taken while a result still waits in the output
// register. Reset (asynchronous, active low) empties the table; entry contents
// are not cleared, as only entries below the member count are ever read.
module sorted_ring_member_table_top import srmt_pkg::*; #(
  parameter int unsigned MaxMembers = MaxMembersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srmt_in_if.sink     in_i,
  srmt_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(MaxMembers + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e         state_q, state_d;
  logic [OpW-1:0] op_q;
  logic [IdW-1:0] id_q;
  logic [CntW-1:0] count_q, count_d;

  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic                 present_q, pv_q, pv_d, sv_q, sv_d;
  logic [IdW-1:0]       pred_q, pred_d, succ_q, succ_d;
  logic [CntW-1:0]      mcount_q;

  srmt_cmd_t      cmd;
  logic [IdW-1:0] val [MaxMembers];
  logic [MaxMembers-1:0] occ, lt, eq, last, pred_sel, succ_sel;
  logic present, eq_last, go, ins_ok, rem_ok;
  logic [CntW+CountOutW-1:0] count_ext;

  // Occupancy as a thermometer of the count; last marks the top entry
  always_comb begin
    for (int i = 0; i < MaxMembers; i++) begin
      occ[i] = CntW'(i) < count_q;
    end
    for (int i = 0; i < MaxMembers; i++) begin
      last[i] = occ[i] && ((i == MaxMembers - 1) ? 1'b1 : !occ[(i + 1) % MaxMembers]);
    end
  end

  assign present = |eq;
  assign eq_last = |(eq & last);
  assign go      = (state_q == S_EVAL) && (!out_valid_q || out_o.ready);
  assign ins_ok  = (op_q == OP_INSERT) && !present && (count_q < CntW'(MaxMembers));
  assign rem_ok  = (op_q == OP_REMOVE) && present;

  assign cmd.upd = go && (ins_ok || rem_ok);
  assign cmd.ins = (op_q == OP_INSERT);
  assign cmd.id  = id_q;

  for (genvar g = 0; g < MaxMembers; g++) begin : g_cell
    logic           left_lt;
    logic [IdW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = id_q;
    end else begin : g_mid
      assign left_lt  = lt[g-1];
      assign left_val = val[g-1];
    end
    if (g == MaxMembers - 1) begin : g_end
      assign right_val = val[g];
    end else begin : g_inner
      assign right_val = val[g+1];
    end
    srmt_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ[g]),
      .left_lt_i   (left_lt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (val[g]),
      .lt_o        (lt[g]),
      .eq_o        (eq[g])
    );
  end

  // Neighbour selection: one-hot over the occupied cells, wrapping at both ends
  always_comb begin
    for (int i = 0; i < MaxMembers; i++) begin
      pred_sel[i] = (eq[0] && last[i]) ||
                    ((i < MaxMembers - 1) ? eq[(i + 1) % MaxMembers] : 1'b0);
      succ_sel[i] = (i == 0) ? eq_last : (occ[i] && eq[(i + MaxMembers - 1) % MaxMembers]);
    end
  end

  always_comb begin
    pred_d = '0;
    succ_d = '0;
    pv_d   = 1'b0;
    sv_d   = 1'b0;
    if (op_q == OP_NEIGH && present) begin
      pv_d = count_q >= CntW'(2);
      sv_d = count_q >= CntW'(3);
    end
    for (int i = 0; i < MaxMembers; i++) begin
      pred_d = pred_d | (pred_sel[i] && pv_d ? val[i] : '0);
      succ_d = succ_d | (succ_sel[i] && sv_d ? val[i] : '0);
    end
  end

  always_comb begin
    status_d = ST_OK;
    case (op_q)
      OP_INSERT: begin
        if (present) status_d = ST_DUP;
        else if (!ins_ok) status_d = ST_FULL;
      end
      OP_REMOVE, OP_TEST, OP_NEIGH: begin
        if (!present) status_d = ST_ABSENT;
      end
      default: status_d = ST_OK;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (go && ins_ok) count_d = count_q + CntW'(1);
    else if (go && rem_ok) count_d = count_q - CntW'(1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_EVAL;
      S_EVAL: if (go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (go) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted beat and the registered result
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q <= in_i.operation;
      id_q <= in_i.member_id;
    end
    if (go) begin
      status_q  <= status_d;
      present_q <= present;
      pv_q      <= pv_d;
      sv_q      <= sv_d;
      pred_q    <= pred_d;
      succ_q    <= succ_d;
      mcount_q  <= count_d;
    end
  end

  assign count_ext = {{CountOutW{1'b0}}, mcount_q};

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.present      = present_q;
  assign out_o.pred_valid   = pv_q;
  assign out_o.predecessor  = pred_q;
  assign out_o.succ_valid   = sv_q;
  assign out_o.successor    = succ_q;
  assign out_o.member_count = count_ext[CountOutW-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxMembers))
    else $error("member count above table depth");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_EVAL)
    else $error("accepted beat not evaluated next cycle");

  a_succ_needs_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sv_q |-> pv_q && present_q && mcount_q >= CntW'(3))
    else $error("successor reported without predecessor or enough members");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && ins_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance the count");

endmodule

FILE: rtl/srmt_cell.sv
module srmt_cell import srmt_pkg::*; (
  input  logic           clk_i,
  input  srmt_cmd_t      cmd_i,
  input  logic           occ_i,
  input  logic           left_lt_i,
  input  logic [IdW-1:0] left_val_i,
  input  logic [IdW-1:0] right_val_i,
  output logic [IdW-1:0] val_o,
  output logic           lt_o,
  output logic           eq_o
);

  logic [IdW-1:0] val_q, val_d;

  assign lt_o  = occ_i && (val_q < cmd_i.id);
  assign eq_o  = occ_i && (val_q == cmd_i.id);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.upd && !lt_o) begin
      if (cmd_i.ins) begin
        // first cell not below the id takes it, the rest take the left value
        val_d = left_lt_i ? cmd_i.id : left_val_i;
      end else begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: dv/sorted_ring_member_table_top_tb.sv
module sorted_ring_member_table_top_tb import srmt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Members     = MaxMembersDef;
  localparam int          RandomItems = 2000;
  localparam int          PoolSize    = 24;

  typedef struct packed {
    srmt_status_e         status;
    logic                 present;
    logic                 pred_valid;
    logic [IdW-1:0]       predecessor;
    logic                 succ_valid;
    logic [IdW-1:0]       successor;
    logic [CountOutW-1:0] member_count;
  } ring_result_t;

  typedef struct {
    srmt_op_e     op;
    logic [IdW-1:0] id;
    logic [IdW-1:0] stride;
    int           reps;
    bit           has_lit;
    ring_result_t lit;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  srmt_in_if  in_bus ();
  srmt_out_if out_bus ();

  sorted_ring_member_table_top #(
    .MaxMembers(Members)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Own copy of the ring, kept in ascending order
  logic [IdW-1:0] ring_ids [Members];
  int unsigned    ring_count;

  ring_result_t expected_results [$];
  ring_result_t predicted;
  ring_result_t observed;

  bit           req_has_lit;
  ring_result_t req_lit;

  int mismatches;
  int op_hits [4];
  int status_hits [4];

  // Rows with a literal result are checked against it, the rest against the predictor.
  directed_row_t directed_rows [18] = '{
    '{OP_TEST,   16'h0000, 16'h0000, 1, 1'b1,
      '{ST_ABSENT, 1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd0}},
    '{OP_NEIGH,  16'hFFFF, 16'h0000, 1, 1'b1,
      '{ST_ABSENT, 1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd0}},
    '{OP_INSERT, 16'h0000, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd1}},
    '{OP_NEIGH,  16'h0000, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd1}},
    '{OP_INSERT, 16'h0000, 16'h0000, 1, 1'b1,
      '{ST_DUP,    1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd1}},
    '{OP_INSERT, 16'hFFFF, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd2}},
    '{OP_NEIGH,  16'hFFFF, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b1, 1'b1, 16'h0000, 1'b0, 16'h0000, 5'd2}},
    '{OP_INSERT, 16'h8000, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd3}},
    '{OP_NEIGH,  16'h0000, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b1, 1'b1, 16'hFFFF, 1'b1, 16'h8000, 5'd3}},
    '{OP_NEIGH,  16'hFFFF, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b1, 1'b1, 16'h8000, 1'b1, 16'h0000, 5'd3}},
    '{OP_INSERT, 16'h1111, 16'h1111, 13, 1'b0, '0},
    '{OP_INSERT, 16'h0001, 16'h0000, 1, 1'b1,
      '{ST_FULL,   1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd16}},
    '{OP_INSERT, 16'h8000, 16'h0000, 1, 1'b1,
      '{ST_DUP,    1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd16}},
    '{OP_REMOVE, 16'h0001, 16'h0000, 1, 1'b1,
      '{ST_ABSENT, 1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd16}},
    '{OP_NEIGH,  16'h5555, 16'h0000, 1, 1'b0, '0},
    '{OP_REMOVE, 16'hFFFF, 16'h0000, 1, 1'b0, '0},
    '{OP_REMOVE, 16'h0000, 16'h0000, 1, 1'b1,
      '{ST_OK,     1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 5'd14}},
    '{OP_NEIGH,  16'h1111, 16'h0000, 1, 1'b0, '0}
  };

  function automatic ring_result_t apply_request(srmt_op_e op, logic [IdW-1:0] id);
    ring_result_t r;
    int unsigned  rank;
    int unsigned  i;
    logic         hit;
    r = '0;
    r.status = ST_OK;
    rank = 0;
    for (i = 0; i < ring_count; i++) begin
      if (ring_ids[i] < id) rank++;
    end
    hit = (rank < ring_count) && (ring_ids[rank] == id);
    case (op)
      OP_INSERT: begin
        if (hit) begin
          r.status = ST_DUP;
        end else if (ring_count >= Members) begin
          r.status = ST_FULL;
        end else begin
          for (i = ring_count; i > rank; i--) ring_ids[i] = ring_ids[i-1];
          ring_ids[rank] = id;
          ring_count++;
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          r.status = ST_ABSENT;
        end else begin
          for (i = rank; i + 1 < ring_count; i++) ring_ids[i] = ring_ids[i+1];
          ring_count--;
        end
      end
      OP_TEST: begin
        r.status = hit ? ST_OK : ST_ABSENT;
      end
      default: begin
        if (!hit) begin
          r.status = ST_ABSENT;
        end else if (ring_count == 2) begin
          r.pred_valid  = 1'b1;
          r.predecessor = ring_ids[(rank == 0) ? 1 : 0];
        end else if (ring_count >= 3) begin
          r.pred_valid  = 1'b1;
          r.succ_valid  = 1'b1;
          r.predecessor = ring_ids[(rank == 0) ? ring_count - 1 : rank - 1];
          r.successor   = ring_ids[(rank + 1 >= ring_count) ? 0 : rank + 1];
        end
      end
    endcase
    r.present      = hit;
    r.member_count = CountOutW'(ring_count);
    return r;
  endfunction

  task automatic check_field(string field, logic [IdW-1:0] want, logic [IdW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", field, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Accept side: predict at the beat, in order
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
      predicted = apply_request(srmt_op_e'(in_bus.operation), in_bus.member_id);
      if (req_has_lit) predicted = req_lit;
      op_hits[in_bus.operation]++;
      status_hits[predicted.status]++;
      expected_results.push_back(predicted);
    end
  end

  // Result side
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $error("result beat with nothing outstanding");
      end else begin
        observed = expected_results.pop_front();
        check_field("status", observed.status, out_bus.status);
        check_field("present", observed.present, out_bus.present);
        check_field("pred_valid", observed.pred_valid, out_bus.pred_valid);
        check_field("predecessor", observed.predecessor, out_bus.predecessor);
        check_field("succ_valid", observed.succ_valid, out_bus.succ_valid);
        check_field("successor", observed.successor, out_bus.successor);
        check_field("member_count", observed.member_count, out_bus.member_count);
      end
    end
  end

  // Receiver: changing stall pattern, plus two long hold-offs to back up the block
  initial begin : receiver
    int cyc;
    int mode;
    int hold_left;
    out_bus.ready = 1'b0;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 3000 || cyc == 15000) hold_left = 90;
      if (cyc % 32 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready = 1'b0;
      end else begin
        case (mode)
          0: out_bus.ready = 1'b1;
          1: out_bus.ready = ($urandom_range(0, 3) != 0);
          2: out_bus.ready = ($urandom_range(0, 3) == 0);
          default: out_bus.ready = cyc[0];
        endcase
      end
    end
  end

  task automatic send_item(srmt_op_e op, logic [IdW-1:0] id, bit has_lit, ring_result_t lit);
    req_has_lit = has_lit;
    req_lit = lit;
    in_bus.operation = op;
    in_bus.member_id = id;
    in_bus.valid = 1'b1;
    do @(posedge clk_i); while (!(in_bus.valid === 1'b1 && in_bus.ready === 1'b1));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int             r;
    int             n;
    int             sent;
    int             burst;
    int             b;
    int             pick;
    int             sel;
    bit             growing;
    srmt_op_e       op;
    logic [IdW-1:0] id;
    logic [IdW-1:0] pool [PoolSize];

    in_bus.valid = 1'b0;
    in_bus.operation = OP_INSERT;
    in_bus.member_id = '0;
    req_has_lit = 1'b0;
    req_lit = '0;
    mismatches = 0;
    ring_count = 0;
    @(posedge rst_ni);
    @(negedge clk_i);

    for (r = 0; r < $size(directed_rows); r++) begin
      for (n = 0; n < directed_rows[r].reps; n++) begin
        send_item(directed_rows[r].op,
                  directed_rows[r].id + directed_rows[r].stride * IdW'(n),
                  directed_rows[r].has_lit, directed_rows[r].lit);
      end
    end
    wait_drained();

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      for (b = 0; b < burst && sent < RandomItems; b++) begin
        // Small rotating pool so the ring fills, empties and hits duplicates
        if (sent % 250 == 0) begin
          foreach (pool[i]) pool[i] = IdW'($urandom);
          if ($urandom_range(0, 1)) pool[0] = '0;
          if ($urandom_range(0, 1)) pool[1] = '1;
        end
        growing = ((sent / 120) % 2) == 0;
        pick = $urandom_range(0, 99);
        if (pick < (growing ? 55 : 20)) op = OP_INSERT;
        else if (pick < (growing ? 70 : 65)) op = OP_REMOVE;
        else if (pick < (growing ? 82 : 77)) op = OP_TEST;
        else op = OP_NEIGH;
        sel = $urandom_range(0, 9);
        if (sel < 7) id = pool[$urandom_range(0, PoolSize - 1)];
        else if (sel < 9 && ring_count > 0) id = ring_ids[$urandom_range(0, ring_count - 1)];
        else id = IdW'($urandom);
        send_item(op, id, 1'b0, '0);
        sent++;
        if (sent == RandomItems / 2) wait_drained();
      end
      in_bus.valid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d requests: %0d insert, %0d remove, %0d test, %0d query",
             op_hits[0] + op_hits[1] + op_hits[2] + op_hits[3],
             op_hits[OP_INSERT], op_hits[OP_REMOVE], op_hits[OP_TEST], op_hits[OP_NEIGH]);
    $display("Outcomes: %0d ok, %0d full, %0d duplicate, %0d absent; %0d mismatches",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_DUP],
             status_hits[ST_ABSENT], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sorted_ring_member_table_top.f
rtl/srmt_pkg.sv
rtl/srmt_in_if.sv
rtl/srmt_out_if.sv
rtl/srmt_cell.sv
rtl/sorted_ring_member_table_top.sv
dv/sorted_ring_member_table_top_tb.sv
